// ===== hdl/stepper_gate_motor_controller_macros.svh =====
// assertion macros used by the gate motor controller core
`ifndef STEPPER_GATE_MOTOR_CONTROLLER_MACROS_SVH
`define STEPPER_GATE_MOTOR_CONTROLLER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SGMC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sgmc assertion failed");

// next-cycle implication, checked outside reset
`define SGMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sgmc assertion failed");

`endif

// ===== hdl/sgmc_pkg.sv =====
// package with types, codes and phase tables of the gate motor controller
package sgmc_pkg;

  localparam int unsigned PhaseCount = 4;
  localparam int unsigned PhaseW     = $clog2(PhaseCount);

  localparam logic [7:0] StepDividerRst   = 8'd13;
  localparam logic [7:0] CyclesPerMoveRst = 8'd60;
  localparam logic [7:0] DriveLatchRst    = 8'hff;

  typedef enum logic [2:0] {
    GM_CLOSE_PEND = 3'd0,
    GM_CLOSED     = 3'd1,
    GM_OPEN_PEND  = 3'd2,
    GM_OPENED     = 3'd3,
    GM_MOVING     = 3'd4
  } gate_mode_e;

  typedef enum logic [1:0] {
    TE_NONE   = 2'd0,
    TE_CLOSED = 2'd1,
    TE_OPENED = 2'd2
  } target_end_e;

  typedef enum logic {
    REG_STEP_DIVIDER    = 1'b0,
    REG_CYCLES_PER_MOVE = 1'b1
  } reg_index_e;

  typedef struct packed {
    logic [7:0] step_divider;
    logic [7:0] cycles_per_move;
  } sgmc_cfg_t;

  // closing sequence
  function automatic logic [7:0] fwd_pattern(input logic [PhaseW-1:0] phase);
    logic [7:0] pat;
    case (phase)
      2'd0:    pat = 8'hf3;
      2'd1:    pat = 8'hf9;
      2'd2:    pat = 8'hfc;
      default: pat = 8'hf6;
    endcase
    return pat;
  endfunction

  // opening sequence
  function automatic logic [7:0] rev_pattern(input logic [PhaseW-1:0] phase);
    logic [7:0] pat;
    case (phase)
      2'd0:    pat = 8'hf3;
      2'd1:    pat = 8'hf6;
      2'd2:    pat = 8'hfc;
      default: pat = 8'hf9;
    endcase
    return pat;
  endfunction

endpackage

// ===== hdl/sgmc_apb_regs.sv =====
// apb configuration registers: step divider and cycles per move
module sgmc_apb_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output sgmc_pkg::sgmc_cfg_t cfg_o
);
  import sgmc_pkg::*;

  logic [7:0] step_divider_q;
  logic [7:0] cycles_per_move_q;
  logic       wr_en;
  reg_index_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_index_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_divider_q    <= StepDividerRst;
      cycles_per_move_q <= CyclesPerMoveRst;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_STEP_DIVIDER:    step_divider_q    <= pwdata[7:0];
        REG_CYCLES_PER_MOVE: cycles_per_move_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_STEP_DIVIDER:    prdata = {24'd0, step_divider_q};
      REG_CYCLES_PER_MOVE: prdata = {24'd0, cycles_per_move_q};
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg_o.step_divider    = step_divider_q;
  assign cfg_o.cycles_per_move = cycles_per_move_q;

endmodule

// ===== hdl/sgmc_core.sv =====
// tick processing: prescaler, phase sequencer, move tracking and result register
`include "stepper_gate_motor_controller_macros.svh"

module sgmc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sgmc_pkg::sgmc_cfg_t cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                toggle_request_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          drive_pattern_o,
  output logic                drive_written_o,
  output logic                move_done_o,
  output logic [2:0]          gate_state_o
);
  import sgmc_pkg::*;

  gate_mode_e        mode_q, mode_d, mode_s;
  target_end_e       target_q, target_d, target_s;
  logic [PhaseW-1:0] phase_q, phase_d, phase_s;
  logic [7:0]        cycle_q, cycle_d, cycle_s, cycle_inc;
  logic [7:0]        tick_q, tick_d, tick_inc;
  logic [7:0]        latch_q, latch_d;
  logic              written_q, written_d;
  logic              done_q, done_d;
  logic              out_valid_q;
  logic              step, drive_en, use_fwd, in_xfer;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    tick_inc  = tick_q + 8'd1;
    step      = tick_inc >= cfg_i.step_divider;
    tick_d    = step ? 8'd0 : tick_inc;
    mode_s    = mode_q;
    target_s  = target_q;
    phase_s   = phase_q;
    cycle_s   = cycle_q;
    cycle_inc = cycle_q + 8'd1;
    latch_d   = latch_q;
    written_d = 1'b0;
    done_d    = 1'b0;
    drive_en  = 1'b0;
    use_fwd   = 1'b0;

    if (step) begin
      unique case (mode_q)
        GM_CLOSE_PEND: begin
          target_s = TE_CLOSED;
          mode_s   = GM_MOVING;
          use_fwd  = 1'b1;
          drive_en = 1'b1;
        end
        GM_OPEN_PEND: begin
          target_s = TE_OPENED;
          mode_s   = GM_MOVING;
          drive_en = 1'b1;
        end
        GM_MOVING: begin
          use_fwd  = (target_q == TE_CLOSED);
          drive_en = (target_q == TE_CLOSED) || (target_q == TE_OPENED);
        end
        default: ;
      endcase
    end

    if (drive_en) begin
      latch_d   = use_fwd ? fwd_pattern(phase_q) : rev_pattern(phase_q);
      written_d = 1'b1;
      if (phase_q == PhaseW'(PhaseCount - 1)) begin
        phase_s = '0;
        if (cycle_inc >= cfg_i.cycles_per_move) begin
          mode_s  = (target_s == TE_CLOSED) ? GM_CLOSED : GM_OPENED;
          cycle_s = 8'd0;
          done_d  = 1'b1;
        end else begin
          cycle_s = cycle_inc;
        end
      end else begin
        phase_s = phase_q + PhaseW'(1);
      end
    end

    // toggle is applied after this tick's step
    mode_d   = mode_s;
    target_d = target_s;
    phase_d  = phase_s;
    cycle_d  = cycle_s;
    if (toggle_request_i) begin
      unique case (mode_s)
        GM_MOVING: begin
          if ((target_s == TE_OPENED) || (target_s == TE_CLOSED)) begin
            mode_d  = (target_s == TE_OPENED) ? GM_CLOSE_PEND : GM_OPEN_PEND;
            // mirror position so the reversal retraces the same distance
            phase_d = PhaseW'(0) - phase_s;
            cycle_d = cfg_i.cycles_per_move - cycle_s;
          end
        end
        GM_CLOSED: mode_d = GM_OPEN_PEND;
        GM_OPENED: mode_d = GM_CLOSE_PEND;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= GM_CLOSED;
      target_q <= TE_NONE;
      phase_q  <= '0;
      cycle_q  <= 8'd0;
      tick_q   <= 8'd0;
      latch_q  <= DriveLatchRst;
    end else if (in_xfer) begin
      mode_q   <= mode_d;
      target_q <= target_d;
      phase_q  <= phase_d;
      cycle_q  <= cycle_d;
      tick_q   <= tick_d;
      latch_q  <= latch_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      written_q <= written_d;
      done_q    <= done_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_pattern_o = latch_q;
  assign drive_written_o = written_q;
  assign move_done_o     = done_q;
  assign gate_state_o    = mode_q;

  `SGMC_ASSERT_IMPL(a_done_has_write, out_valid_q && done_q, written_q)
  `SGMC_ASSERT_IMPL(a_done_not_moving, out_valid_q && done_q, mode_q != GM_MOVING)
  `SGMC_ASSERT_IMPL(a_moving_has_target, mode_q == GM_MOVING,
                    (target_q == TE_CLOSED) || (target_q == TE_OPENED))
  `SGMC_ASSERT_NEXT(a_xfer_gives_result, in_xfer, out_valid_q)

endmodule

// ===== hdl/stepper_gate_motor_controller.sv =====
// top level of the four-phase stepper gate motor controller
// usage:
//   one input transfer is one timer tick carrying toggle_request_i; every tick
//   yields exactly one result with the coil drive byte, a written flag, a
//   move-done flag and the gate state after the tick.
//   the prescaler steps the motor once every step_divider ticks; a step drives
//   the next full-step pattern while a move is pending or running (forward
//   table closing, reverse table opening). throughput: one tick per cycle
//   while the receiver takes each result; the whole tick update is a single
//   pass of logic between the state/result registers and the output register.
//   stall: the output register holds a finished result while out_ready_i is
//   low; a new tick is still taken whenever the held result leaves in the same
//   cycle, otherwise in_ready_o drops until the receiver takes it.
//   reset: gate closed, no target, counters zero, drive byte 0xff, registers
//   at step_divider 13 and cycles_per_move 60, no result pending.
//   configuration: apb writes at byte address 0 (step_divider) and
//   4 (cycles_per_move), low 8 bits used; write only while idle.
module stepper_gate_motor_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        toggle_request_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  drive_pattern_o,
  output logic        drive_written_o,
  output logic        move_done_o,
  output logic [2:0]  gate_state_o
);
  import sgmc_pkg::*;

  sgmc_cfg_t cfg;

  sgmc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sgmc_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .toggle_request_i (toggle_request_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_pattern_o  (drive_pattern_o),
    .drive_written_o  (drive_written_o),
    .move_done_o      (move_done_o),
    .gate_state_o     (gate_state_o)
  );

endmodule

// ===== tb/stepper_gate_motor_controller_tb.sv =====
// testbench for the four-phase stepper gate motor controller
`timescale 1ns / 1ps

module stepper_gate_motor_controller_tb;
  import sgmc_pkg::*;

  typedef struct packed {
    logic [7:0] pattern;
    logic       written;
    logic       done;
    logic [2:0] state;
  } tick_outcome_t;

  // coil patterns per phase, index 0 in the low byte
  localparam logic [3:0][7:0] CloseSeq = {8'hf6, 8'hfc, 8'hf9, 8'hf3};
  localparam logic [3:0][7:0] OpenSeq  = {8'hf9, 8'hfc, 8'hf6, 8'hf3};

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        toggle_request_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  drive_pattern_o;
  logic        drive_written_o;
  logic        move_done_o;
  logic [2:0]  gate_state_o;

  // gate model state
  sgmc_cfg_t   mdl_cfg;
  gate_mode_e  mdl_mode;
  target_end_e mdl_target;
  logic [1:0]  mdl_phase;
  logic [7:0]  mdl_cycles;
  logic [7:0]  mdl_ticks;
  logic [7:0]  mdl_latch;

  tick_outcome_t outcome_q[$];

  int unsigned errors;
  int unsigned ticks_sent;
  int unsigned results_seen;
  int unsigned moves_done;
  int unsigned reversals;
  int unsigned reg_writes;
  int unsigned input_stall_cycles;
  int unsigned hold_cycles;
  int unsigned rx_gap;
  bit          idle_en;

  stepper_gate_motor_controller dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .toggle_request_i (toggle_request_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_pattern_o  (drive_pattern_o),
    .drive_written_o  (drive_written_o),
    .move_done_o      (move_done_o),
    .gate_state_o     (gate_state_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors = errors + 1;
    if (errors <= 40) begin
      $display("mismatch %s: got %0h, expected %0h (result %0d)", what, got, want,
               results_seen);
    end
  endtask

  // one timer tick through the gate model
  function automatic tick_outcome_t advance_gate_model(input logic toggle);
    tick_outcome_t res;
    logic          closing;
    logic          stepping;
    res = '0;
    mdl_ticks = mdl_ticks + 8'd1;
    if (mdl_ticks >= mdl_cfg.step_divider) begin
      mdl_ticks = 8'd0;
      stepping = 1'b1;
      closing = 1'b0;
      case (mdl_mode)
        GM_CLOSE_PEND: begin
          mdl_target = TE_CLOSED;
          mdl_mode = GM_MOVING;
          closing = 1'b1;
        end
        GM_OPEN_PEND: begin
          mdl_target = TE_OPENED;
          mdl_mode = GM_MOVING;
        end
        GM_MOVING: begin
          if (mdl_target == TE_CLOSED) closing = 1'b1;
          else if (mdl_target != TE_OPENED) stepping = 1'b0;
        end
        default: stepping = 1'b0;
      endcase
      if (stepping) begin
        mdl_latch = closing ? CloseSeq[mdl_phase] : OpenSeq[mdl_phase];
        res.written = 1'b1;
        if (mdl_phase == 2'd3) begin
          mdl_phase = 2'd0;
          mdl_cycles = mdl_cycles + 8'd1;
          if (mdl_cycles >= mdl_cfg.cycles_per_move) begin
            mdl_mode = (mdl_target == TE_CLOSED) ? GM_CLOSED : GM_OPENED;
            mdl_cycles = 8'd0;
            res.done = 1'b1;
            moves_done = moves_done + 1;
          end
        end else begin
          mdl_phase = mdl_phase + 2'd1;
        end
      end
    end
    if (toggle) begin
      case (mdl_mode)
        GM_MOVING: begin
          if (mdl_target == TE_OPENED || mdl_target == TE_CLOSED) begin
            mdl_mode = (mdl_target == TE_OPENED) ? GM_CLOSE_PEND : GM_OPEN_PEND;
            // reversal mirrors phase and cycle count, both wrap
            mdl_phase = 2'd0 - mdl_phase;
            mdl_cycles = mdl_cfg.cycles_per_move - mdl_cycles;
            reversals = reversals + 1;
          end
        end
        GM_CLOSED: mdl_mode = GM_OPEN_PEND;
        GM_OPENED: mdl_mode = GM_CLOSE_PEND;
        default: ;
      endcase
    end
    res.pattern = mdl_latch;
    res.state = mdl_mode;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_tick(input logic toggle);
    int unsigned gap;
    gap = (idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    toggle_request_i <= toggle;
    do @(posedge clk_i); while (!in_ready_o);
    outcome_q.push_back(advance_gate_model(toggle));
    ticks_sent = ticks_sent + 1;
  endtask

  task automatic send_random_ticks(input int unsigned count, input int unsigned toggle_pct);
    repeat (count) send_tick($urandom_range(0, 99) < toggle_pct);
  endtask

  // stop offering ticks and let every outstanding result come out
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input reg_index_e idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic read_reg_check(input reg_index_e idx);
    logic [31:0] rdata;
    apb_access(idx, 1'b0, 32'd0, rdata);
    if (idx == REG_STEP_DIVIDER) begin
      if (rdata[7:0] !== mdl_cfg.step_divider)
        report_mismatch("step_divider readback", 32'(rdata[7:0]),
                        32'(mdl_cfg.step_divider));
    end else if (rdata[7:0] !== mdl_cfg.cycles_per_move) begin
      report_mismatch("cycles_per_move readback", 32'(rdata[7:0]),
                      32'(mdl_cfg.cycles_per_move));
    end
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [31:0] value);
    logic [31:0] unused;
    drain_block();
    apb_access(idx, 1'b1, value, unused);
    if (idx == REG_STEP_DIVIDER) mdl_cfg.step_divider = value[7:0];
    else mdl_cfg.cycles_per_move = value[7:0];
    reg_writes = reg_writes + 1;
    read_reg_check(idx);
  endtask

  // compare each result transfer with the oldest predicted tick
  always @(posedge clk_i) begin : check_results
    tick_outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result with no tick pending", 32'(drive_pattern_o), 0);
      end else begin
        want = outcome_q.pop_front();
        if (drive_pattern_o !== want.pattern)
          report_mismatch("drive_pattern", 32'(drive_pattern_o), 32'(want.pattern));
        if (drive_written_o !== want.written)
          report_mismatch("drive_written", 32'(drive_written_o), 32'(want.written));
        if (move_done_o !== want.done)
          report_mismatch("move_done", 32'(move_done_o), 32'(want.done));
        if (gate_state_o !== want.state)
          report_mismatch("gate_state", 32'(gate_state_o), 32'(want.state));
      end
      results_seen = results_seen + 1;
    end
  end

  always @(posedge clk_i) begin
    if (in_valid_i && !in_ready_o) input_stall_cycles = input_stall_cycles + 1;
  end

  // receiver: random gaps, plus a long hold-off when requested
  initial begin : receiver
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_ready_i <= 1'b0;
      end else if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else if (rx_gap > 0) begin
        out_ready_i <= 1'b0;
        rx_gap = rx_gap - 1;
      end else begin
        out_ready_i <= 1'b1;
        if (idle_en && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
      end
    end
  end

  task automatic apply_reset();
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    toggle_request_i = 1'b0;
    mdl_cfg.step_divider = StepDividerRst;
    mdl_cfg.cycles_per_move = CyclesPerMoveRst;
    mdl_mode = GM_CLOSED;
    mdl_target = TE_NONE;
    mdl_phase = 2'd0;
    mdl_cycles = 8'd0;
    mdl_ticks = 8'd0;
    mdl_latch = DriveLatchRst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  // reset register values, toggle while pending, first step and a reversal
  task automatic test_reset_values();
    read_reg_check(REG_STEP_DIVIDER);
    read_reg_check(REG_CYCLES_PER_MOVE);
    send_tick(1'b1);
    send_tick(1'b1);
    repeat (10) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // zero divider steps every tick, zero cycle count ends after the first phase sequence;
  // upper write bits are junk and must be dropped
  task automatic test_zero_registers();
    write_reg(REG_STEP_DIVIDER, 32'hdead_be00);
    write_reg(REG_CYCLES_PER_MOVE, 32'h1234_5600);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // shrink the move length mid-move so the mirrored cycle count wraps
  task automatic test_count_wrap_on_reversal();
    write_reg(REG_STEP_DIVIDER, 32'd1);
    write_reg(REG_CYCLES_PER_MOVE, 32'd3);
    while (mdl_mode != GM_MOVING) send_tick(mdl_mode == GM_CLOSED || mdl_mode == GM_OPENED);
    repeat (9) send_tick(1'b0);
    write_reg(REG_CYCLES_PER_MOVE, 32'd1);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
  endtask

  task automatic test_extreme_settings();
    idle_en = 1'b1;
    write_reg(REG_STEP_DIVIDER, 32'hffff_ffff);
    write_reg(REG_CYCLES_PER_MOVE, 32'h0000_00fe);
    send_random_ticks(260, 1);
    idle_en = 1'b0;
    write_reg(REG_STEP_DIVIDER, 32'h0000_0001);
    write_reg(REG_CYCLES_PER_MOVE, 32'h5a5a_5aff);
    send_random_ticks(40, 10);
  endtask

  task automatic test_random_settings();
    logic [31:0] wdata;
    repeat (8) begin
      idle_en = ($urandom_range(0, 3) != 0);
      wdata = $urandom;
      wdata[7:0] = 8'($urandom_range(0, 3));
      write_reg(REG_STEP_DIVIDER, wdata);
      wdata = $urandom;
      wdata[7:0] = 8'($urandom_range(0, 4));
      write_reg(REG_CYCLES_PER_MOVE, wdata);
      send_random_ticks(35, $urandom_range(3, 15));
    end
  endtask

  // receiver stops for a long stretch while ticks keep coming
  task automatic test_output_backpressure();
    write_reg(REG_STEP_DIVIDER, 32'd2);
    write_reg(REG_CYCLES_PER_MOVE, 32'd2);
    idle_en = 1'b0;
    hold_cycles = 200;
    send_random_ticks(40, 8);
    idle_en = 1'b1;
  endtask

  initial begin : stimulus
    clk_i = 1'b0;
    errors = 0;
    ticks_sent = 0;
    results_seen = 0;
    moves_done = 0;
    reversals = 0;
    reg_writes = 0;
    input_stall_cycles = 0;
    hold_cycles = 0;
    rx_gap = 0;
    idle_en = 1'b1;
    apply_reset();
    test_reset_values();
    test_zero_registers();
    test_count_wrap_on_reversal();
    test_extreme_settings();
    test_random_settings();
    test_output_backpressure();
    drain_block();
    repeat (10) @(posedge clk_i);
    $display("%0d ticks, %0d results, %0d register writes", ticks_sent, results_seen,
             reg_writes);
    $display("%0d moves completed, %0d reversals, %0d cycles with input stalled",
             moves_done, reversals, input_stall_cycles);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
